// ===== sv/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap frame allocator package
// Shared sizes, action codes, controller command and status bundles.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int unsigned MAX_FRAMES = 4096;
  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned BIT_W      = $clog2(WORD_BITS);
  localparam int unsigned WORDS      = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WORD_AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned FRAME_W    = $clog2(MAX_FRAMES + 1);
  localparam int unsigned CFG_W      = 13;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned SUM_W      = ADDR_W + 2;

  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_FREE    = 2'd1;
  localparam logic [1:0] ACT_RESERVE = 2'd2;
  localparam logic [1:0] ACT_RELEASE = 2'd3;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic setup;
    logic rd;
    logic chk;
    logic push;
  } bfa_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic empty;
    logic found;
    logic at_last;
    logic is_alloc;
    logic out_free;
  } bfa_status_t;

  // Limits a frame number to the frames that storage holds.
  function automatic logic [FRAME_W-1:0] clip_frame(input logic [SUM_W-1:0] f);
    logic [FRAME_W-1:0] r;
    if (f > SUM_W'(MAX_FRAMES)) begin
      r = FRAME_W'(MAX_FRAMES);
    end else begin
      r = f[FRAME_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/bitmap_frame_allocator_unit.sv =====
// Sequence: an accepted word is set up, then each bitmap word visited (1 to 128)
// is read in a read state and checked and written back in a check state; an
// empty range skips the check. Allocation stops at the first word with a free
// frame; the result waits in the done state until the output register is free.
// Throughput: one request at a time; the next word is accepted once the last result is in the output register.
// Reset: asynchronous, active low; all frames read as used, frame count is 4096.
// ----------------------------------------------------------------------------
// Bitmap frame allocator
// First-fit page frame allocator with free, reserve and release of byte ranges.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bfa_pkg::CFG_W-1:0]     cfg_wdata_i,   // frames_in_use
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [63:0]                   s_axis_tdata,  // address [31:0], length [63:32]
  input  logic [1:0]                    s_axis_tuser,  // action [1:0]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,  // frame_address [31:0]
  output logic                          m_axis_tuser   // status [0]
);
  import bfa_pkg::*;

  bfa_cmd_t    cmd;
  bfa_status_t st;

  bfa_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .cmd_o         (cmd),
    .st_i          (st)
  );

  bfa_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .action_i          (s_axis_tuser),
    .address_i         (s_axis_tdata[31:0]),
    .length_i          (s_axis_tdata[63:32]),
    .cmd_i             (cmd),
    .st_o              (st),
    .m_valid_o         (m_axis_tvalid),
    .m_ready_i         (m_axis_tready),
    .m_frame_address_o (m_axis_tdata),
    .m_status_o        (m_axis_tuser)
  );

endmodule

// ===== sv/bfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Bitmap frame allocator controller
// Sequences setup, word reads and read-modify-write checks for one request.
// ----------------------------------------------------------------------------
module bfa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  output bfa_pkg::bfa_cmd_t    cmd_o,
  input  bfa_pkg::bfa_status_t st_i
);
  import bfa_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_CHK   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_RD;
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = st_i.empty ? ST_DONE : ST_CHK;
      end
      ST_CHK: begin
        cmd_o.chk = 1'b1;
        if ((st_i.is_alloc && st_i.found) || st_i.at_last) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_DONE: begin
        if (st_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_accept_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == ST_SETUP))
    else $error("accepted word did not start setup");

  a_alloc_hit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHK && st_i.is_alloc && st_i.found) |=> (state_q == ST_DONE))
    else $error("allocation hit did not end the scan");

  a_push_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |=> (state_q == ST_IDLE))
    else $error("result push did not return to idle");
`endif

endmodule

// ===== sv/bfa_dp.sv =====
// ----------------------------------------------------------------------------
// Bitmap frame allocator datapath
// Holds the used bitmap, the frame range of a request and the result register.
// ----------------------------------------------------------------------------
module bfa_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bfa_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic [1:0]                        action_i,
  input  logic [bfa_pkg::ADDR_W-1:0]        address_i,
  input  logic [bfa_pkg::ADDR_W-1:0]        length_i,
  input  bfa_pkg::bfa_cmd_t                 cmd_i,
  output bfa_pkg::bfa_status_t              st_o,
  output logic                              m_valid_o,
  input  logic                              m_ready_i,
  output logic [bfa_pkg::ADDR_W-1:0]        m_frame_address_o,
  output logic                              m_status_o
);
  import bfa_pkg::*;

  logic [CFG_W-1:0]     frames_q;
  logic [1:0]           action_q;
  logic [ADDR_W-1:0]    addr_q, len_q;
  logic [FRAME_W-1:0]   first_q, last_q, first_d, last_d;
  logic [WORD_AW-1:0]   word_q, word_d;
  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORDS-1:0]     valid_q;
  logic [WORD_BITS-1:0] rdata_q;
  logic                 rvalid_q;
  logic [ADDR_W-1:0]    res_addr_q, res_addr_d;
  logic                 res_status_q, res_status_d;
  logic                 m_valid_q;
  logic [ADDR_W-1:0]    m_addr_q;
  logic                 m_status_q;

  logic [SUM_W-1:0]     free_f, rel_first, res_last, rel_last, addr_w;
  logic [FRAME_W-1:0]   last_m1;
  logic [WORD_AW-1:0]   first_word, last_word;
  logic [BIT_W-1:0]     lo, hi, hit_idx;
  logic [WORD_BITS-1:0] cur, mask, cand, wdata;
  logic                 is_alloc, empty, found, at_last, we;

  // Frame range of the request, formed once after the request is latched.
  always_comb begin
    addr_w    = SUM_W'(addr_q);
    free_f    = addr_w >> PAGE_SHIFT;
    rel_first = (addr_w + SUM_W'(PAGE_BYTES - 1)) >> PAGE_SHIFT;
    res_last  = (addr_w + SUM_W'(len_q) + SUM_W'(PAGE_BYTES - 1)) >> PAGE_SHIFT;
    rel_last  = (addr_w + SUM_W'(len_q)) >> PAGE_SHIFT;
    case (action_q)
      ACT_ALLOC: begin
        first_d = '0;
        last_d  = clip_frame(SUM_W'(frames_q));
      end
      ACT_FREE: begin
        first_d = clip_frame(free_f);
        last_d  = clip_frame(free_f + SUM_W'(1));
      end
      ACT_RESERVE: begin
        first_d = clip_frame(free_f);
        last_d  = clip_frame(res_last);
      end
      default: begin
        first_d = clip_frame(rel_first);
        last_d  = clip_frame(rel_last);
      end
    endcase
  end

  // Per-word mask of the frames inside the range, and the lowest free one.
  always_comb begin
    is_alloc   = (action_q == ACT_ALLOC);
    empty      = (first_q >= last_q);
    last_m1    = last_q - FRAME_W'(1);
    first_word = first_q[WORD_AW+BIT_W-1:BIT_W];
    last_word  = last_m1[WORD_AW+BIT_W-1:BIT_W];
    at_last    = (word_q == last_word);
    lo         = (word_q == first_word) ? first_q[BIT_W-1:0] : '0;
    hi         = at_last ? last_m1[BIT_W-1:0] : BIT_W'(WORD_BITS - 1);
    cur        = rvalid_q ? rdata_q : '1;
    mask       = ({WORD_BITS{1'b1}} << lo) &
                 ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi));
    cand       = ~cur & mask;
    found      = |cand;
    hit_idx    = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        hit_idx = BIT_W'(i);
      end
    end
    case (action_q)
      ACT_ALLOC:   wdata = cur | (WORD_BITS'(1) << hit_idx);
      ACT_RESERVE: wdata = cur | mask;
      default:     wdata = cur & ~mask;
    endcase
    we = cmd_i.chk && (!is_alloc || found);
  end

  always_comb begin
    word_d       = word_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    if (cmd_i.load) begin
      res_addr_d   = '0;
      res_status_d = 1'b0;
    end
    if (cmd_i.setup) begin
      word_d = first_d[WORD_AW+BIT_W-1:BIT_W];
    end
    if (cmd_i.rd && empty && is_alloc) begin
      res_status_d = 1'b1;
    end
    if (cmd_i.chk) begin
      if (is_alloc && found) begin
        res_addr_d = ADDR_W'({word_q, hit_idx}) << PAGE_SHIFT;
      end else if (at_last) begin
        res_status_d = is_alloc;
      end else begin
        word_d = word_q + WORD_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= action_i;
      addr_q   <= address_i;
      len_q    <= length_i;
    end
    if (cmd_i.setup) begin
      first_q <= first_d;
      last_q  <= last_d;
    end
    word_q       <= word_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    if (cmd_i.push) begin
      m_addr_q   <= res_addr_q;
      m_status_q <= res_status_q;
    end
  end

  // Bitmap store: an entry never written reads as all frames used.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[word_q] <= wdata;
    end
    if (cmd_i.rd) begin
      rdata_q  <= mem[word_q];
      rvalid_q <= valid_q[word_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      frames_q  <= CFG_W'(MAX_FRAMES);
      m_valid_q <= 1'b0;
    end else begin
      if (we) begin
        valid_q[word_q] <= 1'b1;
      end
      if (cfg_we_i) begin
        frames_q <= cfg_wdata_i;
      end
      if (cmd_i.push) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    st_o.empty    = empty;
    st_o.found    = found;
    st_o.at_last  = at_last;
    st_o.is_alloc = is_alloc;
    st_o.out_free = !m_valid_q || m_ready_i;
  end

  assign m_valid_o         = m_valid_q;
  assign m_frame_address_o = m_addr_q;
  assign m_status_o        = m_status_q;

`ifndef SYNTHESIS
  a_fail_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.push && res_status_q) |-> (res_addr_q == '0))
    else $error("failed allocation carries a nonzero address");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.chk |-> (word_q >= first_word && word_q <= last_word))
    else $error("bitmap word outside the request range");

  a_alloc_sets_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && is_alloc) |-> (wdata != cur))
    else $error("allocation wrote back an unchanged word");
`endif

endmodule

// ===== tb/bitmap_frame_allocator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Bitmap frame allocator testbench
// Drives alloc, free, reserve and release words into the allocator under
// several frame counts, keeps its own copy of the frame bitmap, and checks
// every result word against the predicted grant in order.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_unit_tb;
  import bfa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned RANDOM_PER_PHASE = 150;
  localparam int unsigned PHASES = 8;

  typedef struct {
    logic [31:0] frame_address;
    logic        status;
  } grant_t;

  // Mirror of the frame bitmap and the queue of grants still owed by the block.
  class frame_ledger;
    bit          used [MAX_FRAMES];
    logic [12:0] frame_count;
    grant_t      expected_grants [$];
    logic [31:0] granted_pages [$];
    int          errors;
    int          hits;
    int          misses;
    int          frees;
    int          reserves;
    int          releases;

    function new();
      foreach (used[i]) used[i] = 1'b1;
      frame_count = 13'd4096;
      errors      = 0;
      hits        = 0;
      misses      = 0;
      frees       = 0;
      reserves    = 0;
      releases    = 0;
    endfunction

    function logic [63:0] cap_to_storage(input logic [63:0] f);
      return (f > 64'(MAX_FRAMES)) ? 64'(MAX_FRAMES) : f;
    endfunction

    function void note_request(input logic [1:0] action, input logic [31:0] address,
                               input logic [31:0] length);
      logic [63:0] pg;
      logic [63:0] a;
      logic [63:0] l;
      logic [63:0] lo;
      logic [63:0] hi;
      int          f;
      grant_t      g;
      pg = 64'(PAGE_BYTES);
      a  = {32'd0, address};
      l  = {32'd0, length};
      g.frame_address = '0;
      g.status        = 1'b0;
      case (action)
        ACT_ALLOC: begin
          g.status = 1'b1;
          hi = cap_to_storage(64'(frame_count));
          for (f = 0; f < int'(hi) && g.status; f++) begin
            if (!used[f]) begin
              used[f]         = 1'b1;
              g.frame_address = 32'(64'(f) * pg);
              g.status        = 1'b0;
            end
          end
          if (g.status) begin
            misses++;
          end else begin
            hits++;
            granted_pages.push_back(g.frame_address);
          end
        end
        ACT_FREE: begin
          frees++;
          lo = a / pg;
          if (lo < 64'(MAX_FRAMES)) used[int'(lo)] = 1'b0;
        end
        ACT_RESERVE: begin
          // Outward alignment: any frame the range touches becomes used.
          reserves++;
          lo = cap_to_storage(a / pg);
          hi = cap_to_storage((a + l + pg - 1) / pg);
          for (f = int'(lo); f < int'(hi); f++) used[f] = 1'b1;
        end
        default: begin
          // Inward alignment: only frames wholly inside the range are freed.
          releases++;
          lo = cap_to_storage((a + pg - 1) / pg);
          hi = cap_to_storage((a + l) / pg);
          for (f = int'(lo); f < int'(hi); f++) used[f] = 1'b0;
        end
      endcase
      expected_grants.push_back(g);
    endfunction

    function void check_grant(input logic [31:0] frame_address, input logic status);
      grant_t g;
      if (expected_grants.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, frame_address %h status %0d",
                 $time, frame_address, status);
        return;
      end
      g = expected_grants.pop_front();
      if (frame_address !== g.frame_address) begin
        errors++;
        $display("%0t: frame_address mismatch, expected %h, actual %h",
                 $time, g.frame_address, frame_address);
      end
      if (status !== g.status) begin
        errors++;
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, g.status, status);
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CFG_W-1:0]  cfg_wdata_i;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [63:0]       s_axis_tdata;   // address [31:0], length [63:32]
  logic [1:0]        s_axis_tuser;   // action [1:0]
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [31:0]       m_axis_tdata;   // frame_address [31:0]
  logic              m_axis_tuser;   // status [0]

  frame_ledger ledger;
  logic        idling_on;
  int          ready_burst = 0;
  int unsigned cycle_count = 0;
  int          settings_used = 0;

  bitmap_frame_allocator_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding",
               $time, ledger.expected_grants.size());
      $display("bitmap_frame_allocator_unit test failed");
      $finish;
    end
  end

  // Result side back-pressure: alternating ready and stall bursts while idling_on is set.
  always @(posedge clk_i) begin
    if (ready_burst > 0) begin
      ready_burst--;
    end else if (idling_on && $urandom_range(0, 2) == 0) begin
      m_axis_tready <= 1'b0;
      ready_burst = $urandom_range(0, 7);
    end else begin
      m_axis_tready <= 1'b1;
      ready_burst = $urandom_range(0, 15);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      ledger.check_grant(m_axis_tdata, m_axis_tuser);
  end

  task automatic send_request(input logic [1:0] action, input logic [31:0] address,
                              input logic [31:0] length);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {length, address};
    s_axis_tuser  <= action;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    ledger.note_request(action, address, length);
  endtask

  // Holds the input off until every owed result word has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (ledger.expected_grants.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_frame_count(input logic [12:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    ledger.frame_count = value;
    settings_used++;
  endtask

  task automatic random_request();
    int unsigned pick;
    int unsigned frame;
    int unsigned pages;
    int          idx;
    logic [1:0]  action;
    logic [31:0] address;
    logic [31:0] length;
    pick    = $urandom_range(0, 99);
    address = $urandom;
    length  = $urandom;
    frame   = $urandom_range(0, MAX_FRAMES + 104);
    pages   = $urandom_range(0, 8);
    if (pick < 35) begin
      action = ACT_ALLOC;
    end else if (pick < 55) begin
      action = ACT_FREE;
      if (ledger.granted_pages.size() != 0 && $urandom_range(0, 2) != 0) begin
        idx     = $urandom_range(0, ledger.granted_pages.size() - 1);
        address = ledger.granted_pages[idx] | $urandom_range(0, PAGE_BYTES - 1);
        ledger.granted_pages.delete(idx);
      end else begin
        address = frame * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1);
      end
    end else if (pick < 92) begin
      action  = (pick < 70) ? ACT_RESERVE : ACT_RELEASE;
      address = frame * PAGE_BYTES;
      length  = pages * PAGE_BYTES;
      if ($urandom_range(0, 1) != 0) address = address + $urandom_range(0, PAGE_BYTES - 1);
      if ($urandom_range(0, 1) != 0) length = length + $urandom_range(0, PAGE_BYTES - 1);
      if ($urandom_range(0, 9) == 0) length = $urandom_range(0, MAX_FRAMES * PAGE_BYTES);
    end else begin
      // Noise: any action with fully random address and length.
      action = 2'($urandom);
    end
    send_request(action, address, length);
  endtask

  initial begin
    logic [12:0] count_setting;
    ledger = new();
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ACT_ALLOC;
    m_axis_tready <= 1'b0;
    idling_on     <= 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every frame starts out used, so the first alloc must be refused.
    send_request(ACT_ALLOC,   32'h0000_0000, 32'h0000_0000);
    send_request(ACT_RELEASE, 32'h0000_0000, 32'h0100_0000);
    send_request(ACT_ALLOC,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(ACT_ALLOC,   32'h0000_0000, 32'h0000_0000);
    send_request(ACT_FREE,    32'h0000_0FFF, 32'h0000_0000);
    send_request(ACT_ALLOC,   32'h0000_0000, 32'h0000_0000);
    send_request(ACT_RESERVE, 32'h0000_2345, 32'h0000_0000);
    send_request(ACT_RESERVE, 32'h0000_5000, 32'h0000_0000);
    send_request(ACT_RELEASE, 32'h0000_1001, 32'h0000_1000);
    send_request(ACT_FREE,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(ACT_RESERVE, 32'hFFFF_F000, 32'hFFFF_FFFF);
    send_request(ACT_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(ACT_RESERVE, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(ACT_ALLOC,   32'h0000_0000, 32'h0000_0000);
    send_request(ACT_RELEASE, 32'h00FF_F000, 32'h0000_1000);
    wait_drained();
    write_frame_count(13'd0);
    send_request(ACT_ALLOC,   32'h0000_0000, 32'h0000_0000);
    wait_drained();
    // A count past storage still stops the scan at the last stored frame.
    write_frame_count(13'd8191);
    send_request(ACT_ALLOC,   32'h0000_0000, 32'h0000_0000);
    send_request(ACT_ALLOC,   32'h0000_0000, 32'h0000_0000);
    wait_drained();
    write_frame_count(13'd1);
    send_request(ACT_RELEASE, 32'h0000_0800, 32'h0000_2800);
    send_request(ACT_ALLOC,   32'h0000_0000, 32'h0000_0000);
    send_request(ACT_FREE,    32'h0000_0000, 32'h0000_0000);
    send_request(ACT_ALLOC,   32'h0000_0000, 32'h0000_0000);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0:       count_setting = 13'd8191;
        1:       count_setting = 13'd4096;
        2:       count_setting = 13'd1;
        3:       count_setting = 13'd37;
        4:       count_setting = 13'd0;
        5:       count_setting = 13'($urandom_range(0, 8191));
        6:       count_setting = 13'd4095;
        default: count_setting = 13'd2048;
      endcase
      if (p == PHASES - 1) idling_on <= 1'b0;
      write_frame_count(count_setting);
      repeat (RANDOM_PER_PHASE) random_request();
    end
    wait_drained();
    repeat (300) @(posedge clk_i);

    $display("Covered %0d allocs (%0d granted, %0d refused), %0d frees, %0d reserves, %0d releases",
             ledger.hits + ledger.misses, ledger.hits, ledger.misses,
             ledger.frees, ledger.reserves, ledger.releases);
    $display("across %0d frame count settings, with stalls on both streams but in the last phase",
             settings_used);
    if (ledger.errors == 0) begin
      $display("bitmap_frame_allocator_unit test passed");
    end else begin
      $display("bitmap_frame_allocator_unit test failed");
    end
    $finish;
  end

endmodule
